### hdl/rsb_pkg.sv
// Shared types, constants and helper functions for the serial frame register bridge.
package rsb_pkg;

  localparam int NUM_DEVICES      = 7;
  localparam int WORDS_PER_DEVICE = 8;
  localparam int FRAME_LEN        = 10;

  localparam int STORE_WORDS = NUM_DEVICES * WORDS_PER_DEVICE;
  localparam int ADDR_W      = $clog2(STORE_WORDS);

  localparam logic [7:0] START_CH   = 8'h3A;
  localparam logic [7:0] END_CH     = 8'h23;
  localparam logic [7:0] POLL_CH    = 8'h50;
  localparam logic [7:0] BASE_ADDR  = 8'hA0;
  localparam logic [7:0] LOCAL_ADDR = 8'hA1;

  localparam int REPLY_LEN  = 10;
  localparam int PAD_TO     = 40;
  localparam int POLL_LEN   = 42;
  localparam int POLL_FIRST = 3;
  localparam int POLL_WORD  = 4;
  localparam int POLL_DEVS  = (NUM_DEVICES >= 7) ? 4 :
                              ((NUM_DEVICES > POLL_FIRST) ? NUM_DEVICES - POLL_FIRST : 0);
  localparam bit POLL_OK    = (POLL_WORD < WORDS_PER_DEVICE);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    REQ_READ,
    REQ_WRITE,
    REQ_POLL
  } req_kind_t;

  typedef struct packed {
    logic              valid;
    req_kind_t         kind;
    logic [7:0]        addr;
    logic [7:0]        idx;
    logic [31:0]       value;
    logic              word_ok;
    logic [ADDR_W-1:0] mem_addr;
  } req_t;

  function automatic logic [31:0] preset_value(input logic [ADDR_W-1:0] a);
    logic [31:0] v;
    v = 32'd0;
    if (WORDS_PER_DEVICE > 1 && 32'(a) == 32'(WORDS_PER_DEVICE + 1))
      v = 32'd300;
    if (POLL_OK && NUM_DEVICES > 4 && 32'(a) == 32'(4 * WORDS_PER_DEVICE + POLL_WORD))
      v = 32'd512;
    if (POLL_OK && NUM_DEVICES > 6 && 32'(a) == 32'(6 * WORDS_PER_DEVICE + POLL_WORD))
      v = 32'd512;
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] poll_addr(input logic [2:0] g);
    logic [31:0] a;
    a = 32'd0;
    if (POLL_OK)
      a = (32'(g) + 32'(POLL_FIRST)) * 32'(WORDS_PER_DEVICE) + 32'(POLL_WORD);
    return ADDR_W'(a);
  endfunction

endpackage

### hdl/rsb_store.sv
// Register store memory: one write port, one read port with registered read data.
module rsb_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [rsb_pkg::ADDR_W-1:0] waddr,
  input  logic [31:0]               wdata,
  input  logic                      re,
  input  logic [rsb_pkg::ADDR_W-1:0] raddr,
  output logic [31:0]               rdata
);
  import rsb_pkg::*;

  logic [31:0] mem [STORE_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/rsb_frame.sv
// Request frame gathering, end byte check and address decode.
module rsb_frame (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    rx_byte,
  output rsb_pkg::req_t req
);
  import rsb_pkg::*;

  logic [3:0]        frame_count;
  logic [7:0]        frame_bytes [8];
  logic [2:0]        fb_idx;
  logic [7:0]        f_addr;
  logic [7:0]        f_idx;
  logic [6:0]        dev;
  logic [2:0]        word;
  logic              poll_hit;
  logic              dev_hit;
  logic              req_hit;
  logic              req_valid;
  req_kind_t         req_kind;
  logic [7:0]        req_addr;
  logic [7:0]        req_idx;
  logic [31:0]       req_value;
  logic              req_word_ok;
  logic [ADDR_W-1:0] req_mem_addr;

  assign fb_idx   = 3'(frame_count - 4'd1);
  assign f_addr   = frame_bytes[0];
  assign f_idx    = frame_bytes[1];
  assign dev      = f_addr[7:1] - BASE_ADDR[7:1];
  assign word     = f_idx[2:0];
  assign poll_hit = (f_addr == LOCAL_ADDR) && (f_idx == POLL_CH);
  assign dev_hit  = (f_addr > LOCAL_ADDR) && (dev < 7'(NUM_DEVICES));
  assign req_hit  = take && (frame_count == 4'(FRAME_LEN - 1)) && (rx_byte == END_CH) &&
                    (poll_hit || dev_hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= 4'd0;
      req_valid   <= 1'b0;
    end else begin
      req_valid <= req_hit;
      if (take) begin
        if (frame_count == 4'd0) begin
          if (rx_byte == START_CH) begin
            frame_count <= 4'd1;
          end
        end else if (frame_count < 4'(FRAME_LEN - 1)) begin
          frame_count <= frame_count + 4'd1;
        end else begin
          frame_count <= 4'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && frame_count != 4'd0 && frame_count < 4'(FRAME_LEN - 1)) begin
      frame_bytes[fb_idx] <= rx_byte;
    end
    if (req_hit) begin
      req_kind     <= poll_hit ? REQ_POLL : (f_addr[0] ? REQ_READ : REQ_WRITE);
      req_addr     <= f_addr;
      req_idx      <= f_idx;
      req_value    <= {frame_bytes[5], frame_bytes[4], frame_bytes[3], frame_bytes[2]};
      req_word_ok  <= (9'(word) < 9'(WORDS_PER_DEVICE));
      req_mem_addr <= ADDR_W'(32'(dev) * 32'(WORDS_PER_DEVICE) + 32'(word));
    end
  end

  assign req.valid    = req_valid;
  assign req.kind     = req_kind;
  assign req.addr     = req_addr;
  assign req.idx      = req_idx;
  assign req.value    = req_value;
  assign req.word_ok  = req_word_ok;
  assign req.mem_addr = req_mem_addr;

endmodule

### hdl/rsb_reply.sv
// Reply sequencer: store clearing pass, register access and reply byte emission.
module rsb_reply (
  input  logic                       clk,
  input  logic                       rst,
  input  rsb_pkg::req_t              req,
  input  logic [31:0]                rdata,
  output logic                       we,
  output logic [rsb_pkg::ADDR_W-1:0] waddr,
  output logic [31:0]                wdata,
  output logic                       re,
  output logic [rsb_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                 tx_byte,
  output logic                       frame_end,
  output logic                       strobe,
  output logic                       busy
);
  import rsb_pkg::*;

  state_t            state;
  state_t            state_next;
  req_kind_t         kind;
  logic [7:0]        addr;
  logic [7:0]        idx;
  logic              word_ok;
  logic [5:0]        pos;
  logic [2:0]        grp;
  logic [2:0]        off;
  logic [7:0]        sum;
  logic [ADDR_W-1:0] clr_addr;
  logic              in_grp;
  logic              last;
  logic              add_sum;
  logic [31:0]       wd;
  logic [1:0]        k;

  assign in_grp = (pos >= 6'd3) && (grp < 3'(POLL_DEVS));
  assign last   = (kind == REQ_POLL) ? (pos == 6'(POLL_LEN - 1)) : (pos == 6'(REPLY_LEN - 1));
  assign wd     = ((kind == REQ_POLL) ? POLL_OK : word_ok) ? rdata : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = '0;
    wdata      = 32'd0;
    re         = 1'b0;
    raddr      = '0;
    tx_byte    = 8'd0;
    frame_end  = 1'b0;
    strobe     = 1'b0;
    add_sum    = 1'b0;
    k          = 2'd0;
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = preset_value(clr_addr);
        if (clr_addr == ADDR_W'(STORE_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_EMIT;
          if (req.kind == REQ_READ) begin
            re    = 1'b1;
            raddr = req.mem_addr;
          end
          if (req.kind == REQ_WRITE && req.word_ok) begin
            we    = 1'b1;
            waddr = req.mem_addr;
            wdata = req.value;
          end
        end
      end
      ST_EMIT: begin
        strobe    = 1'b1;
        frame_end = last;
        if (last) begin
          state_next = ST_IDLE;
        end
        unique case (kind)
          REQ_READ: begin
            k = 2'(pos - 6'd3);
            priority if (pos == 6'd0) tx_byte = START_CH;
            else if (pos == 6'd1) tx_byte = addr;
            else if (pos == 6'd2) tx_byte = idx;
            else if (pos <= 6'd6) tx_byte = wd[8*k +: 8];
            else if (pos == 6'd7) tx_byte = sum;
            else if (pos == 6'd8) tx_byte = 8'd0;
            else tx_byte = END_CH;
            add_sum = (pos >= 6'd1) && (pos <= 6'd6);
          end
          REQ_WRITE: begin
            priority if (pos == 6'd0) tx_byte = START_CH;
            else if (pos == 6'd1) tx_byte = addr;
            else if (pos == 6'(REPLY_LEN - 1)) tx_byte = END_CH;
            else tx_byte = 8'd0;
          end
          REQ_POLL: begin
            k = 2'(off - 3'd2);
            add_sum = in_grp;
            if (in_grp && off == 3'd0) begin
              re    = 1'b1;
              raddr = poll_addr(grp);
            end
            priority if (pos == 6'd0) tx_byte = START_CH;
            else if (pos == 6'd1) tx_byte = LOCAL_ADDR;
            else if (pos == 6'd2) tx_byte = POLL_CH;
            else if (in_grp) begin
              priority if (off == 3'd0)
                tx_byte = 8'(32'(BASE_ADDR) + 32'd2 * (32'(grp) + 32'(POLL_FIRST)) + 32'd1);
              else if (off == 3'd1) tx_byte = 8'(POLL_WORD);
              else tx_byte = wd[8*k +: 8];
            end
            else if (pos < 6'(PAD_TO)) tx_byte = 8'd0;
            else if (pos == 6'(PAD_TO)) tx_byte = sum;
            else tx_byte = END_CH;
          end
          default: begin
            tx_byte = 8'd0;
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      pos      <= 6'd0;
      grp      <= 3'd0;
      off      <= 3'd0;
      sum      <= 8'd0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == ST_IDLE && req.valid) begin
        pos <= 6'd0;
        grp <= 3'd0;
        off <= 3'd0;
        sum <= 8'd0;
      end
      if (state == ST_EMIT) begin
        pos <= pos + 6'd1;
        if (add_sum) begin
          sum <= sum + tx_byte;
        end
        if (kind == REQ_POLL && in_grp) begin
          if (off == 3'd5) begin
            off <= 3'd0;
            grp <= grp + 3'd1;
          end else begin
            off <= off + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      kind    <= req.kind;
      addr    <= req.addr;
      idx     <= req.idx;
      word_ok <= req.word_ok;
    end
  end

  assign busy = (state != ST_IDLE) || req.valid;

endmodule

### hdl/serial_frame_register_bridge.sv
// Top level of the serial frame register bridge.
// The closing '#' byte sets the request register, then the state register starts the reply.
// Throughput: one received byte per cycle while idle; busy holds while a reply of 10 bytes
// (read or write) or 42 bytes (poll) goes out, one byte per cycle.
// Reset: synchronous; a clearing pass over all STORE_WORDS (56) words loads the store.
// The receiver cannot stall: each reply byte shows on strobe for one cycle.
module serial_frame_register_bridge (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] rx_byte,
  output logic       strobe,
  output logic [7:0] tx_byte,
  output logic       frame_end
);
  import rsb_pkg::*;

  req_t              req;
  logic              take;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [31:0]       wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [31:0]       rdata;

  assign take = start && !busy;

  rsb_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .req     (req)
  );

  rsb_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  rsb_reply u_reply (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rdata     (rdata),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .re        (re),
    .raddr     (raddr),
    .tx_byte   (tx_byte),
    .frame_end (frame_end),
    .strobe    (strobe),
    .busy      (busy)
  );

endmodule

### hdl/rsb_checker.sv
// Port-level assertions for the serial frame register bridge and their bind.
module rsb_checker (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       strobe,
  input logic [7:0] tx_byte,
  input logic       frame_end
);
  import rsb_pkg::*;

  a_end_byte: assert property (@(posedge clk) disable iff (rst)
    frame_end |-> (strobe && tx_byte == END_CH))
    else $error("frame_end without closing byte");

  a_busy_reply: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("reply byte while not busy");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> (busy && !strobe))
    else $error("not clearing after reset");

  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !frame_end) |=> strobe)
    else $error("gap inside reply");

  a_reply_gap: assert property (@(posedge clk) disable iff (rst)
    frame_end |=> !strobe)
    else $error("reply byte right after closing byte");

endmodule

bind serial_frame_register_bridge rsb_checker u_rsb_checker (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .strobe    (strobe),
  .tx_byte   (tx_byte),
  .frame_end (frame_end)
);
